### sv/assert_macros.svh
// Assertion macros shared by the interrupt controller RTL.
// Standalone; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### sv/irqsf_pkg.sv
// Types, codes and defaults for the interrupt controller with SOF filtering.
// No dependencies; imported by every other file of the block except assert_macros.svh.
`default_nettype none

package irqsf_pkg;

	// Defaults for top-level parameters
	localparam int NUM_LINES_DEF  = 64;
	localparam int FRAME_BITS_DEF = 14;

	// Field widths fixed by the item format
	localparam int LINE_W    = 6;
	localparam int PEND_W    = 64;
	localparam int FRAME_W   = 14;
	localparam int FRAME_EXT_W = 16;
	localparam int COUNT_W   = 8;

	// Configuration port
	localparam int REG_IDX_W  = 2;
	localparam int REG_DATA_W = 8;
	localparam logic [REG_IDX_W-1:0] REG_USB_IRQ_LINE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SOF_PASS_LIMIT = 2'd1;

	localparam logic [LINE_W-1:0]  USB_IRQ_LINE_RST   = 6'd9;
	localparam logic [COUNT_W-1:0] SOF_PASS_LIMIT_RST = 8'(8 * 20);

	typedef enum logic [1:0] {
		OP_TAKE        = 2'd0,
		OP_ENABLE      = 2'd1,
		OP_DISABLE     = 2'd2,
		OP_DISABLE_ALL = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [LINE_W-1:0]  irq_line;
		logic [PEND_W-1:0]  pending_raw;
		logic               sof_flag;
		logic [FRAME_W-1:0] cur_frame;
		logic [FRAME_W-1:0] target_frame;
		logic               target_valid;
		logic               kick;
	} req_item_t;

	typedef struct packed {
		logic              irq_valid;
		logic [LINE_W-1:0] irq_number;
		logic              sof_ack;
		logic              swallowed;
	} rsp_item_t;

	// Priority encoder result
	typedef struct packed {
		logic              found;
		logic [LINE_W-1:0] line;
	} pick_t;

endpackage

`default_nettype wire

### sv/irqsf_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on irqsf_pkg.
`default_nettype none

interface irqsf_req_if import irqsf_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/irqsf_rsp_if.sv
// Result channel: valid/ready handshake carrying one result word.
// Depends on irqsf_pkg.
`default_nettype none

interface irqsf_rsp_if import irqsf_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/irqsf_mask.sv
// Per-line enable mask register with enable, disable and disable-all updates.
// Depends on irqsf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module irqsf_mask import irqsf_pkg::*; #(
	parameter int NUM_LINES = NUM_LINES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire req_item_t            item,
	output logic [NUM_LINES-1:0]      mask
);

	localparam int IDX_W = $clog2(NUM_LINES);

	logic [NUM_LINES-1:0] mask_q;
	logic                 line_ok;
	logic [IDX_W-1:0]     idx;

	assign line_ok = {1'b0, item.irq_line} < (LINE_W + 1)'(NUM_LINES);
	assign idx     = item.irq_line[IDX_W-1:0];
	assign mask    = mask_q;

	// Mask update on each word leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (fire) begin
			unique case (item.op)
				OP_ENABLE: begin
					if (line_ok) mask_q[idx] <= 1'b1;
				end
				OP_DISABLE: begin
					if (line_ok) mask_q[idx] <= 1'b0;
				end
				OP_DISABLE_ALL: begin
					mask_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	`ASSERT_CLK(a_disable_all_clears, clk, arst_n, fire && item.op == OP_DISABLE_ALL |=> mask_q == '0, "disable-all left lines enabled")

endmodule

`default_nettype wire

### sv/irqsf_pick.sv
// Priority encoder: lowest line that is both pending and enabled.
// Depends on irqsf_pkg.
`default_nettype none

module irqsf_pick import irqsf_pkg::*; #(
	parameter int NUM_LINES = NUM_LINES_DEF
) (
	input  wire logic [PEND_W-1:0]    pending,
	input  wire logic [NUM_LINES-1:0] mask,
	output pick_t                     pick
);

	logic [NUM_LINES-1:0] active;

	assign active = pending[NUM_LINES-1:0] & mask;

	// Scan from the top so the lowest set bit wins
	always_comb begin
		pick.found = |active;
		pick.line  = '0;
		for (int i = NUM_LINES - 1; i >= 0; i--) begin
			if (active[i]) pick.line = LINE_W'(i);
		end
	end

endmodule

`default_nettype wire

### sv/irqsf_filter.sv
// SOF filter: SOF counter, wrap-aware frame compare and result build.
// Depends on irqsf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module irqsf_filter import irqsf_pkg::*; #(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire req_item_t          item,
	input  wire pick_t              pick,
	input  wire logic [LINE_W-1:0]  usb_line,
	input  wire logic [COUNT_W-1:0] pass_limit,
	output rsp_item_t               res
);

	localparam int FRAME_TOP = (1 << FRAME_BITS) - 1;
	localparam logic [FRAME_BITS-1:0] HALF = FRAME_BITS'(FRAME_TOP / 2);

	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    count_inc;
	logic [FRAME_BITS-1:0] host;
	logic [FRAME_BITS-1:0] target;
	logic                  reached;
	logic                  take;
	logic                  is_sof;
	logic                  hit;
	logic                  swallow;

	assign host   = FRAME_BITS'({{(FRAME_EXT_W - FRAME_W){1'b0}}, item.cur_frame});
	assign target = FRAME_BITS'({{(FRAME_EXT_W - FRAME_W){1'b0}}, item.target_frame});

	// Scheduled frame reached, allowing for wrap of the frame number
	always_comb begin
		if (host < target) reached = (target - host) >= HALF;
		else               reached = (host - target) < HALF;
	end

	assign take      = item.op == OP_TAKE && pick.found;
	assign is_sof    = take && pick.line == usb_line && item.sof_flag;
	assign count_inc = count_q + COUNT_W'(1);
	assign hit       = count_inc == pass_limit;
	assign swallow   = is_sof && !hit && item.target_valid && !item.kick && !reached;

	// Result word
	always_comb begin
		res.irq_valid  = take && !swallow;
		res.irq_number = take ? pick.line : '0;
		res.sof_ack    = swallow;
		res.swallowed  = swallow;
	end

	// SOF counter, cleared when it reaches the pass limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire && is_sof) begin
			count_q <= hit ? '0 : count_inc;
		end
	end

	`ASSERT_CLK(a_count_idle, clk, arst_n, !fire |=> $stable(count_q), "SOF counter moved without a word")
	`ASSERT_CLK(a_swallow_usb, clk, arst_n, fire && res.swallowed |-> pick.line == usb_line && item.sof_flag, "swallowed a non-SOF request")

endmodule

`default_nettype wire

### sv/irq_controller_sof_filter.sv
// Interrupt controller with per-line enable mask and local SOF filtering.
// Each word is registered in the input stage, then its result in the result register.
// Throughput: one request word per cycle unless rsp.ready stalls the result register.
// Result register holds a finished word while the next request is registered.
// Reset (arst_n low, asynchronous): all lines disabled, SOF counter zero,
// USB line 9, pass limit 160, both stages empty.
`default_nettype none
`include "assert_macros.svh"

module irq_controller_sof_filter import irqsf_pkg::*; #(
	parameter int NUM_LINES  = NUM_LINES_DEF,
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	irqsf_req_if.sink                  req,
	irqsf_rsp_if.source                rsp,
	input  wire logic                  cfg_we,
	input  wire logic [REG_IDX_W-1:0]  cfg_idx,
	input  wire logic [REG_DATA_W-1:0] cfg_wdata
);

	logic [LINE_W-1:0]    usb_line_q;
	logic [COUNT_W-1:0]   pass_limit_q;
	logic                 valid_s1;
	req_item_t            item_s1;
	logic                 out_valid_q;
	rsp_item_t            out_q;
	logic                 advance;
	logic                 fire;
	logic [NUM_LINES-1:0] mask;
	pick_t                pick;
	rsp_item_t            res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usb_line_q   <= USB_IRQ_LINE_RST;
			pass_limit_q <= SOF_PASS_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_USB_IRQ_LINE:   usb_line_q   <= cfg_wdata[LINE_W-1:0];
				REG_SOF_PASS_LIMIT: pass_limit_q <= cfg_wdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: input stage moves on when the result register is free
	assign advance   = !out_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) item_s1 <= req.data;
	end

	irqsf_mask #(.NUM_LINES(NUM_LINES)) u_mask (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.mask   (mask)
	);

	irqsf_pick #(.NUM_LINES(NUM_LINES)) u_pick (
		.pending (item_s1.pending_raw),
		.mask    (mask),
		.pick    (pick)
	);

	irqsf_filter #(.FRAME_BITS(FRAME_BITS)) u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.pick       (pick),
		.usb_line   (usb_line_q),
		.pass_limit (pass_limit_q),
		.res        (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) out_q <= res;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	`ASSERT_CLK(a_s1_held, clk, arst_n, valid_s1 && !advance |=> valid_s1 && $stable(item_s1), "input stage lost a word under stall")
	`ASSERT_NEVER(a_swallow_excl, clk, arst_n, out_valid_q && out_q.swallowed && out_q.irq_valid, "result both delivered and swallowed")

endmodule

`default_nettype wire
